>>> rtl/core/rgbmed_pkg.sv
// shared types and constants of the rgb 3x3 median filter
`timescale 1ns / 1ps
`default_nettype none

package rgbmed_pkg;

    localparam int CHAN_W   = 8;
    localparam int WIN_SIZE = 9;
    localparam int COUNT_W  = 4;

    localparam logic [COUNT_W-1:0] FULL_SIZE  = 4'd9;
    localparam logic [COUNT_W-1:0] SHIFT_SIZE = 4'd3;
    localparam logic [COUNT_W-1:0] RIGHT_COL  = 4'd2;
    localparam logic [COUNT_W-1:0] ROW_LEN    = 4'd3;

    localparam int MID_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 2;

    typedef enum logic
    {
        MODE_SHIFT = 1'b0,
        MODE_FULL  = 1'b1
    } mode_t;

    typedef struct packed
    {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pixel_t;

    typedef pixel_t [WIN_SIZE-1:0] window_t;

    localparam int WIN_W = $bits(window_t);
    localparam int PIX_W = $bits(pixel_t);

endpackage

`default_nettype wire

>>> rtl/core/rgb_median3x3_sliding_window.sv
// top level of the rgb 3x3 sliding-window median filter
//
// input side is a queue: pixel beats (red_in, green_in, blue_in, func) are taken
// on a clock edge with push high and full low, one beat per cycle as long as full stays low.
// func on the first beat of a group picks the mode: 1 loads all nine window
// positions row by row, 0 shifts the window left and loads the right column
// from three beats, rows top to bottom. func on later beats is ignored.
// result side is a queue too: when empty is low the oldest per-channel median
// sits on red_med, green_med, blue_med and leaves on an edge with pop high.
// one result per completed group; it passes through the window queue, network
// stage one, network stage two and the output queue before it shows on the
// outputs. the median network is split over two register stages and takes one
// window per cycle while the output queue has room.
// if pop is held low, results back up through the output queue, the network
// and the window queue, then full rises; beats that finish no group are held
// off too while the window queue is full.
// reset clears the window to zero, the group count and mode, and all queues.
`timescale 1ns / 1ps
`default_nettype none

module rgb_median3x3_sliding_window
    import rgbmed_pkg::*;
#(
    parameter int MID_DEPTH = MID_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [CHAN_W-1:0] red_in,
    input  wire logic [CHAN_W-1:0] green_in,
    input  wire logic [CHAN_W-1:0] blue_in,
    input  wire logic              func,
    output logic                   empty,
    input  wire logic              pop,
    output logic [CHAN_W-1:0]      red_med,
    output logic [CHAN_W-1:0]      green_med,
    output logic [CHAN_W-1:0]      blue_med
);

    pixel_t           pixel;
    logic             mid_push, mid_full, mid_pop, mid_empty;
    window_t          mid_wdata, mid_rdata;
    logic [WIN_W-1:0] mid_rvec;
    logic             out_push, out_full;
    pixel_t           out_wdata, out_rdata;
    logic [PIX_W-1:0] out_rvec;

    assign pixel.red   = red_in;
    assign pixel.green = green_in;
    assign pixel.blue  = blue_in;

    rgbmed_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .func   (func),
        .pixel  (pixel),
        .full   (full),
        .q_push (mid_push),
        .q_data (mid_wdata),
        .q_full (mid_full)
    );

    rgbmed_fifo #(.WIDTH(WIN_W), .DEPTH(MID_DEPTH)) u_mid_q
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_wdata),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rvec),
        .empty (mid_empty)
    );

    assign mid_rdata = mid_rvec;

    rgbmed_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (mid_empty),
        .q_data  (mid_rdata),
        .q_pop   (mid_pop),
        .o_push  (out_push),
        .o_data  (out_wdata),
        .o_full  (out_full)
    );

    rgbmed_fifo #(.WIDTH(PIX_W), .DEPTH(OUT_DEPTH)) u_out_q
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_wdata),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rvec),
        .empty (empty)
    );

    assign out_rdata = out_rvec;
    assign red_med   = out_rdata.red;
    assign green_med = out_rdata.green;
    assign blue_med  = out_rdata.blue;

endmodule

`default_nettype wire

>>> rtl/core/rgbmed_fifo.sv
// small register queue used between the stages of the median filter
`timescale 1ns / 1ps
`default_nettype none

module rgbmed_fifo
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rgbmed_front.sv
// front end: takes pixel beats, builds the 3x3 window, hands finished windows on
`timescale 1ns / 1ps
`default_nettype none

module rgbmed_front
    import rgbmed_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire logic   func,
    input  wire pixel_t pixel,
    output logic        full,
    output logic        q_push,
    output window_t     q_data,
    input  wire logic   q_full
);

    window_t              window_reg, window_next;
    window_t              win_base;
    logic [COUNT_W-1:0]   group_count_reg, group_count_next;
    mode_t                group_mode_reg, group_mode_next;
    logic [COUNT_W-1:0]   size;
    logic [COUNT_W-1:0]   slot;
    logic [COUNT_W-1:0]   slot_inc;
    logic [COUNT_W-1:0]   pos;
    logic                 accept;
    logic                 done;

    assign full   = q_full;
    assign accept = push && !q_full;

    always_comb
    begin
        win_base        = window_reg;
        group_mode_next = group_mode_reg;
        if (group_count_reg == '0)
        begin
            group_mode_next = mode_t'(func);
            if (group_mode_next == MODE_SHIFT)
            begin
                // move every row one column left
                win_base[0] = window_reg[1];
                win_base[1] = window_reg[2];
                win_base[3] = window_reg[4];
                win_base[4] = window_reg[5];
                win_base[6] = window_reg[7];
                win_base[7] = window_reg[8];
            end
        end
        size = (group_mode_next == MODE_FULL) ? FULL_SIZE : SHIFT_SIZE;
        slot = (group_count_reg >= size) ? '0 : group_count_reg;
        pos  = (group_mode_next == MODE_FULL) ? slot : slot * ROW_LEN + RIGHT_COL;
        window_next      = win_base;
        window_next[pos] = pixel;
        slot_inc         = slot + 1'b1;
        done             = (slot_inc == size);
        group_count_next = done ? '0 : slot_inc;
    end

    assign q_push = accept && done;
    assign q_data = window_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg      <= '0;
            group_count_reg <= '0;
            group_mode_reg  <= MODE_SHIFT;
        end
        else if (accept)
        begin
            window_reg      <= window_next;
            group_count_reg <= group_count_next;
            group_mode_reg  <= group_mode_next;
        end
    end

    // count stays inside a full-mode group
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        group_count_reg <= FULL_SIZE - 1'b1)
        else $error("group count out of range");

    // a shift-mode group never runs past its column
    a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (group_mode_reg == MODE_SHIFT) |-> (group_count_reg < SHIFT_SIZE))
        else $error("shift group too long");

    // mode is latched from the first beat of a group
    a_mode_latch: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && group_count_reg == '0) |=> (group_mode_reg == mode_t'($past(func))))
        else $error("group mode not taken from first beat");

endmodule

`default_nettype wire

>>> rtl/core/rgbmed_back.sv
// back end: two-stage compare-exchange network giving the median of nine per channel
`timescale 1ns / 1ps
`default_nettype none

module rgbmed_back
    import rgbmed_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    q_empty,
    input  wire window_t q_data,
    output logic         q_pop,
    output logic         o_push,
    output pixel_t       o_data,
    input  wire logic    o_full
);

    typedef logic [WIN_SIZE-1:0][CHAN_W-1:0] byte9_t;

    function automatic byte9_t cx(byte9_t p, logic [3:0] a, logic [3:0] b);
        byte9_t           q;
        logic [CHAN_W-1:0] t;
        q = p;
        if (p[a] > p[b])
        begin
            t    = p[a];
            q[a] = p[b];
            q[b] = t;
        end
        return q;
    endfunction

    function automatic byte9_t net_a(byte9_t p);
        byte9_t q;
        q = p;
        q = cx(q, 4'd1, 4'd2); q = cx(q, 4'd4, 4'd5); q = cx(q, 4'd7, 4'd8);
        q = cx(q, 4'd0, 4'd1); q = cx(q, 4'd3, 4'd4); q = cx(q, 4'd6, 4'd7);
        q = cx(q, 4'd1, 4'd2); q = cx(q, 4'd4, 4'd5); q = cx(q, 4'd7, 4'd8);
        q = cx(q, 4'd0, 4'd3); q = cx(q, 4'd5, 4'd8); q = cx(q, 4'd4, 4'd7);
        return q;
    endfunction

    function automatic logic [CHAN_W-1:0] net_b(byte9_t p);
        byte9_t q;
        q = p;
        q = cx(q, 4'd3, 4'd6); q = cx(q, 4'd1, 4'd4); q = cx(q, 4'd2, 4'd5);
        q = cx(q, 4'd4, 4'd7); q = cx(q, 4'd2, 4'd4); q = cx(q, 4'd4, 4'd6);
        q = cx(q, 4'd2, 4'd4);
        return q[4];
    endfunction

    byte9_t               s1_reg [3];
    byte9_t               s1_next [3];
    logic                 v1_reg;
    pixel_t               s2_reg, s2_next;
    logic                 v2_reg;
    logic                 s1_ready;
    logic                 s2_ready;

    assign s2_ready = !v2_reg || !o_full;
    assign s1_ready = !v1_reg || s2_ready;
    assign q_pop    = s1_ready && !q_empty;
    assign o_push   = v2_reg;
    assign o_data   = s2_reg;

    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        byte9_t col;
        for (genvar i = 0; i < WIN_SIZE; i++)
        begin : g_tap
            assign col[i] = q_data[i][CHAN_W*c +: CHAN_W];
        end
        assign s1_next[c] = net_a(col);
    end

    assign s2_next.red   = net_b(s1_reg[0]);
    assign s2_next.green = net_b(s1_reg[1]);
    assign s2_next.blue  = net_b(s1_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                v1_reg <= q_pop;
            end
            if (s2_ready)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_reg <= s1_next;
        end
        if (s2_ready)
        begin
            s2_reg <= s2_next;
        end
    end

    // a stalled result stays put until the output queue has room
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && o_full) |=> (v2_reg && $stable(s2_reg)))
        else $error("stage two lost a stalled result");

    // stage one holds while stage two is blocked
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !s2_ready) |=> v1_reg)
        else $error("stage one dropped a window");

    // a window taken from the queue always lands in stage one
    a_pop_lands: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> v1_reg)
        else $error("popped window not captured");

endmodule

`default_nettype wire
